FILE: rtl/core/sdbs_pkg.sv
package sdbs_pkg;

  localparam int unsigned CmdW  = 2;
  localparam int unsigned RowW  = 9;
  localparam int unsigned ColW  = 10;
  localparam int unsigned PixW  = 8;
  localparam int unsigned PaddrW = 4;
  localparam int unsigned PdataW = 32;

  typedef enum logic [CmdW-1:0] {
    CMD_INIT_PIXEL = 2'd0,
    CMD_INIT_BLANK = 2'd1,
    CMD_UPDATE     = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    REG_VAR_MIN = 2'd0,
    REG_VAR_MAX = 2'd1,
    REG_AMP     = 2'd2
  } reg_idx_e;

  localparam logic [PixW-1:0] VarMinReset = 8'd1;
  localparam logic [PixW-1:0] VarMaxReset = 8'd254;
  localparam logic [PixW-1:0] AmpReset    = 8'd2;
  localparam logic [PixW-1:0] PixMax      = 8'd255;

  // Mean and variance of one pixel, kept together in one memory word.
  typedef struct packed {
    logic [PixW-1:0] mean;
    logic [PixW-1:0] var_est;
  } entry_t;

endpackage

FILE: rtl/core/sdbs_pix_if.sv
interface sdbs_pix_if;
  import sdbs_pkg::*;

  logic            valid;
  logic            ready;
  logic [CmdW-1:0] command;
  logic [RowW-1:0] row;
  logic [ColW-1:0] col;
  logic [PixW-1:0] pixel;

  modport source (output valid, command, row, col, pixel, input ready);
  modport sink   (input valid, command, row, col, pixel, output ready);
endinterface

FILE: rtl/core/sdbs_res_if.sv
interface sdbs_res_if;
  import sdbs_pkg::*;

  logic            valid;
  logic            ready;
  logic            foreground;
  logic [PixW-1:0] difference;

  modport source (output valid, foreground, difference, input ready);
  modport sink   (input valid, foreground, difference, output ready);
endinterface

FILE: rtl/core/sigma_delta_background_subtract.sv
// Per-pixel sigma-delta background estimator with motion classification.
// Pixel beats arrive on in_i (command, row, col, pixel); result beats
// (foreground, difference) leave on out_o, one for each update command.
// Init commands and beats with an unused command or a coordinate outside the
// frame are taken and produce no result beat.
// Throughput is one beat per cycle unless a stalled out_o holds an update. The
// stored mean and variance live in one memory with a single read port and a
// single write port; the entry is read at the accepting edge and written back
// as its beat leaves stage 1. The last write is forwarded so that back-to-back
// beats to the same pixel see it. Results pass stage 1 and the output register.
// When out_o stalls, the output register holds; an update behind it holds
// too and drops in_i.ready, while an init behind it still completes.
// in_i.ready is high whenever the output register is empty.
// Reset clears the pipeline and loads the registers with variance_min = 1,
// variance_max = 254 and amplification = 2. The memory is not cleared: every
// pixel is to be initialized by an init command before its first update.
// Registers sit on the APB port at byte addresses 0, 4 and 8; pready is
// always high and writes take effect at the access cycle.
module sigma_delta_background_subtract #(
  parameter int unsigned IMAGE_WIDTH  = 1024,
  parameter int unsigned IMAGE_HEIGHT = 512
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  sdbs_pix_if.sink                     in_i,
  sdbs_res_if.source                   out_o,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [sdbs_pkg::PaddrW-1:0]  paddr,
  input  logic [sdbs_pkg::PdataW-1:0]  pwdata,
  output logic [sdbs_pkg::PdataW-1:0]  prdata,
  output logic                         pready
);
  import sdbs_pkg::*;

  localparam int unsigned Depth = IMAGE_WIDTH * IMAGE_HEIGHT;
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned ProdW = AddrW + RowW + ColW;

  // Configuration registers.
  logic [PixW-1:0] var_min_q, var_max_q, amp_q;
  logic            cfg_wr;
  reg_idx_e        cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = reg_idx_e'(paddr[3:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      var_min_q <= VarMinReset;
      var_max_q <= VarMaxReset;
      amp_q     <= AmpReset;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_VAR_MIN: var_min_q <= pwdata[PixW-1:0];
        REG_VAR_MAX: var_max_q <= pwdata[PixW-1:0];
        REG_AMP:     amp_q     <= pwdata[PixW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    case (cfg_idx)
      REG_VAR_MIN: prdata = PdataW'(var_min_q);
      REG_VAR_MAX: prdata = PdataW'(var_max_q);
      REG_AMP:     prdata = PdataW'(amp_q);
      default:     prdata = '0;
    endcase
  end

  // Stage 0: address and range check.
  logic             in_acc, in_ok;
  logic [ProdW-1:0] addr_wide;
  logic [AddrW-1:0] in_addr;

  assign in_acc    = in_i.valid && in_i.ready;
  assign addr_wide = ProdW'(in_i.row) * ProdW'(IMAGE_WIDTH) + ProdW'(in_i.col);
  assign in_addr   = addr_wide[AddrW-1:0];
  assign in_ok     = (32'(in_i.row) < IMAGE_HEIGHT) && (32'(in_i.col) < IMAGE_WIDTH) &&
                     (in_i.command == CMD_INIT_PIXEL || in_i.command == CMD_INIT_BLANK ||
                      in_i.command == CMD_UPDATE);

  // Stage 1 holds one item whose memory word has been read.
  logic             s1_valid_q;
  cmd_e             s1_cmd_q;
  logic [AddrW-1:0] s1_addr_q;
  logic [PixW-1:0]  s1_pix_q;
  logic             s1_adv;

  entry_t           mem_q [Depth];
  entry_t           rdata_q;

  // Last write, forwarded over the read that was issued at the same edge.
  logic             wb_valid_q;
  logic [AddrW-1:0] wb_addr_q;
  entry_t           wb_data_q;

  logic             out_valid_q, out_fg_q;
  logic [PixW-1:0]  out_diff_q;

  assign s1_adv     = !s1_valid_q || (s1_cmd_q != CMD_UPDATE) || !out_valid_q || out_o.ready;
  assign in_i.ready = s1_adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s1_adv) begin
      s1_valid_q <= in_acc && in_ok;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_cmd_q  <= cmd_e'(in_i.command);
      s1_addr_q <= in_addr;
      s1_pix_q  <= in_i.pixel;
      rdata_q   <= mem_q[in_addr];
    end
  end

  // Stage 1 arithmetic.
  entry_t          cur, new_entry;
  logic [PixW-1:0] m_new, diff, v_step, v_hi;
  logic [15:0]     target;
  logic            s1_wr;

  assign cur = (wb_valid_q && wb_addr_q == s1_addr_q) ? wb_data_q : rdata_q;

  always_comb begin
    if (cur.mean < s1_pix_q) begin
      m_new = cur.mean + 8'd1;
    end else if (cur.mean > s1_pix_q) begin
      m_new = cur.mean - 8'd1;
    end else begin
      m_new = cur.mean;
    end
    diff   = (m_new > s1_pix_q) ? (m_new - s1_pix_q) : (s1_pix_q - m_new);
    target = 16'(diff) * 16'(amp_q);
    // The increment saturates at full scale before the clamp.
    if (16'(cur.var_est) < target) begin
      v_step = (cur.var_est == PixMax) ? PixMax : cur.var_est + 8'd1;
    end else if (16'(cur.var_est) > target) begin
      v_step = cur.var_est - 8'd1;
    end else begin
      v_step = cur.var_est;
    end
    // Upper limit first, then the floor, so a floor above the ceiling wins.
    v_hi = (v_step > var_max_q) ? var_max_q : v_step;
    case (s1_cmd_q)
      CMD_INIT_PIXEL: new_entry = '{mean: s1_pix_q, var_est: var_min_q};
      CMD_INIT_BLANK: new_entry = '{mean: var_max_q, var_est: var_min_q};
      default:        new_entry = '{mean: m_new,
                                    var_est: (v_hi < var_min_q) ? var_min_q : v_hi};
    endcase
  end

  assign s1_wr = s1_valid_q && s1_adv;

  always_ff @(posedge clk_i) begin
    if (s1_wr) begin
      mem_q[s1_addr_q] <= new_entry;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wb_valid_q <= 1'b0;
    end else if (s1_wr) begin
      wb_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_wr) begin
      wb_addr_q <= s1_addr_q;
      wb_data_q <= new_entry;
    end
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_wr && s1_cmd_q == CMD_UPDATE) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_wr && s1_cmd_q == CMD_UPDATE) begin
      out_fg_q   <= !(diff < new_entry.var_est);
      out_diff_q <= diff;
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.foreground = out_fg_q;
  assign out_o.difference = out_diff_q;

endmodule

FILE: rtl/core/sdbs_checker.sv
module sdbs_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_ready_i,
  input logic out_valid_i,
  input logic out_ready_i,
  input logic out_fg_i,
  input logic [7:0] out_diff_i
);

  // A clock edge under reset leaves no result beat offered.
  a_reset_quiet: assert property (@(posedge clk_i) !rst_ni |=> !out_valid_i)
    else $error("result beat offered after a reset edge");

  // An empty output register never holds back the input side.
  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_i |-> in_ready_i)
    else $error("input stalled with an empty output register");

  a_valid_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result beat withdrawn before it was taken");

  a_payload_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(out_fg_i) && $stable(out_diff_i))
    else $error("stalled result beat changed");

endmodule

bind sigma_delta_background_subtract sdbs_checker u_sdbs_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_ready_i (in_i.ready),
  .out_valid_i(out_o.valid),
  .out_ready_i(out_o.ready),
  .out_fg_i   (out_o.foreground),
  .out_diff_i (out_o.difference)
);

FILE: dv/sigma_delta_background_subtract_tb.sv
`timescale 1ns / 100ps

module sigma_delta_background_subtract_tb;
  import sdbs_pkg::*;

  localparam int unsigned FrameW     = 1024;
  localparam int unsigned FrameH     = 512;
  localparam int unsigned PoolSize   = 24;
  localparam int unsigned StallLimit = 2000;
  localparam int unsigned SettleCyc  = 4;
  localparam logic [CmdW-1:0] CMD_UNUSED = 2'd3;

  typedef struct packed {
    logic [CmdW-1:0] cmd;
    logic [RowW-1:0] row;
    logic [ColW-1:0] col;
    logic [PixW-1:0] pix;
  } pix_beat_t;

  typedef struct packed {
    logic            fg;
    logic [PixW-1:0] diff;
  } verdict_t;

  logic clk_i;
  logic rst_ni;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [PaddrW-1:0] paddr;
  logic [PdataW-1:0] pwdata;
  logic [PdataW-1:0] prdata;
  logic              pready;

  sdbs_pix_if pix_if ();
  sdbs_res_if res_if ();

  sigma_delta_background_subtract #(
    .IMAGE_WIDTH (FrameW),
    .IMAGE_HEIGHT(FrameH)
  ) dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (pix_if),
    .out_o  (res_if),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  pix_beat_t feed_q[$];
  verdict_t  verdict_q[$];

  // Shadow of the block's registers and per-pixel stores.
  logic [PixW-1:0] var_floor;
  logic [PixW-1:0] var_ceil;
  logic [PixW-1:0] amp_gain;
  logic [PixW-1:0] mean_ref[int unsigned];
  logic [PixW-1:0] var_ref[int unsigned];

  // Pixels that have seen an init, tracked in the order beats are queued.
  bit              primed[int unsigned];
  logic [RowW-1:0] pool_row[PoolSize];
  logic [ColW-1:0] pool_col[PoolSize];
  logic [PixW-1:0] pool_scene[PoolSize];
  int unsigned     last_slot;

  bit          steady;
  int unsigned fault_cnt;
  int unsigned quiet_cycles;

  function automatic int unsigned pixel_addr(logic [RowW-1:0] row, logic [ColW-1:0] col);
    return int'(row) * FrameW + int'(col);
  endfunction

  function automatic bit in_frame(logic [RowW-1:0] row, logic [ColW-1:0] col);
    return (int'(row) < FrameH) && (int'(col) < FrameW);
  endfunction

  task automatic log_fault(string what);
    fault_cnt++;
    if (fault_cnt <= 10) $display("[%0t] mismatch: %s", $time, what);
  endtask

  // Applies one accepted beat to the shadow stores; returns 1 when it yields a result.
  function automatic bit sd_classify(pix_beat_t b, output verdict_t vd);
    int unsigned addr, m, v, d, goal;
    vd = '0;
    if (b.cmd == CMD_UNUSED || !in_frame(b.row, b.col)) return 1'b0;
    addr = pixel_addr(b.row, b.col);
    if (b.cmd == CMD_INIT_PIXEL || b.cmd == CMD_INIT_BLANK) begin
      mean_ref[addr] = (b.cmd == CMD_INIT_PIXEL) ? b.pix : var_ceil;
      var_ref[addr] = var_floor;
      return 1'b0;
    end
    m = mean_ref[addr];
    if (m < b.pix) m++;
    else if (m > b.pix) m--;
    mean_ref[addr] = PixW'(m);
    d = (m > b.pix) ? m - b.pix : b.pix - m;
    // The target is kept at full width; the increment stops at 255.
    v = var_ref[addr];
    goal = d * amp_gain;
    if (v < goal) begin
      if (v < 255) v++;
    end else if (v > goal) begin
      v--;
    end
    if (v > var_ceil) v = var_ceil;
    if (v < var_floor) v = var_floor;
    var_ref[addr] = PixW'(v);
    vd.fg = (d < v) ? 1'b0 : 1'b1;
    vd.diff = PixW'(d);
    return 1'b1;
  endfunction

  always @(posedge clk_i) begin : feed_drive
    pix_beat_t nxt;
    pix_beat_t took;
    verdict_t vd;
    if (!rst_ni) begin
      pix_if.valid <= 1'b0;
    end else begin
      if (pix_if.valid && pix_if.ready) begin
        took.cmd = pix_if.command;
        took.row = pix_if.row;
        took.col = pix_if.col;
        took.pix = pix_if.pixel;
        if (sd_classify(took, vd)) verdict_q.push_back(vd);
      end
      if (!pix_if.valid || pix_if.ready) begin
        if (feed_q.size() != 0 && (steady || $urandom_range(99) >= 10)) begin
          nxt = feed_q.pop_front();
          pix_if.valid   <= 1'b1;
          pix_if.command <= nxt.cmd;
          pix_if.row     <= nxt.row;
          pix_if.col     <= nxt.col;
          pix_if.pixel   <= nxt.pix;
        end else begin
          pix_if.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i) begin : result_check
    verdict_t want;
    if (!rst_ni) begin
      res_if.ready <= 1'b0;
    end else begin
      res_if.ready <= steady || ($urandom_range(99) >= 10);
      if (res_if.valid && res_if.ready) begin
        if (verdict_q.size() == 0) begin
          log_fault($sformatf("result beat fg=%0b diff=%0d with nothing expected",
                              res_if.foreground, res_if.difference));
        end else begin
          want = verdict_q.pop_front();
          if (res_if.foreground !== want.fg)
            log_fault($sformatf("foreground expected %0b, got %0b", want.fg,
                                res_if.foreground));
          if (res_if.difference !== want.diff)
            log_fault($sformatf("difference expected %0d, got %0d", want.diff,
                                res_if.difference));
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      quiet_cycles <= 0;
    end else if ((pix_if.valid && pix_if.ready) || (res_if.valid && res_if.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= StallLimit) begin
      $display("watchdog: no beat accepted for %0d cycles", quiet_cycles);
      $display("== FAIL ==");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic push_beat(logic [CmdW-1:0] cmd, logic [RowW-1:0] row, logic [ColW-1:0] col,
                           logic [PixW-1:0] pix);
    pix_beat_t b;
    b.cmd = cmd;
    b.row = row;
    b.col = col;
    b.pix = pix;
    feed_q.push_back(b);
    if ((cmd == CMD_INIT_PIXEL || cmd == CMD_INIT_BLANK) && in_frame(row, col))
      primed[pixel_addr(row, col)] = 1'b1;
  endtask

  task automatic apb_write(reg_idx_e idx, logic [PixW-1:0] val);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= PdataW'(val);
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_VAR_MIN: var_floor = val;
      REG_VAR_MAX: var_ceil  = val;
      REG_AMP:     amp_gain  = val;
      default: ;
    endcase
  endtask

  task automatic apb_check(reg_idx_e idx, logic [PixW-1:0] want);
    logic [PdataW-1:0] got;
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {idx, 2'b00};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    got = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    if (got !== PdataW'(want))
      log_fault($sformatf("register %s read expected %0d, got %0d", idx.name(), want, got));
  endtask

  task automatic check_regs();
    apb_check(REG_VAR_MIN, var_floor);
    apb_check(REG_VAR_MAX, var_ceil);
    apb_check(REG_AMP, amp_gain);
  endtask

  task automatic set_config(logic [PixW-1:0] vmin, logic [PixW-1:0] vmax,
                            logic [PixW-1:0] amp);
    apb_write(REG_VAR_MIN, vmin);
    apb_write(REG_VAR_MAX, vmax);
    apb_write(REG_AMP, amp);
    check_regs();
  endtask

  // Inits can still be in flight when the last result arrives, so let the pipeline settle.
  task automatic drain();
    while (feed_q.size() != 0 || pix_if.valid || verdict_q.size() != 0) @(negedge clk_i);
    repeat (SettleCyc) @(posedge clk_i);
  endtask

  task automatic random_beat(output bit counted);
    int unsigned r;
    int unsigned s;
    int p;
    r = $urandom_range(99);
    counted = 1'b1;
    if (r < 4) begin
      push_beat(CMD_UNUSED, RowW'($urandom), ColW'($urandom), PixW'($urandom));
      counted = 1'b0;
    end else if (r < 8) begin
      push_beat(($urandom_range(1) != 0) ? CMD_INIT_BLANK : CMD_INIT_PIXEL,
                RowW'($urandom), ColW'($urandom), PixW'($urandom));
    end else begin
      // Often hit the same pixel again so back-to-back updates meet in the pipe.
      s = (r < 28) ? last_slot : $urandom_range(PoolSize - 1);
      last_slot = s;
      if (!primed.exists(pixel_addr(pool_row[s], pool_col[s])) || r < 14) begin
        push_beat(($urandom_range(3) == 0) ? CMD_INIT_BLANK : CMD_INIT_PIXEL,
                  pool_row[s], pool_col[s], pool_scene[s]);
      end else begin
        case ($urandom_range(7))
          0: p = $urandom_range(255);
          1: begin
            pool_scene[s] = PixW'($urandom_range(255));
            p = pool_scene[s];
          end
          default: p = int'(pool_scene[s]) + int'($urandom_range(16)) - 8;
        endcase
        if (p < 0) p = 0;
        if (p > 255) p = 255;
        push_beat(CMD_UPDATE, pool_row[s], pool_col[s], PixW'(p));
      end
    end
  endtask

  task automatic run_phase(int unsigned n);
    int unsigned done;
    bit counted;
    done = 0;
    while (done < n) begin
      random_beat(counted);
      if (counted) done++;
    end
    drain();
  endtask

  initial begin
    rst_ni         = 1'b0;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = '0;
    pwdata         = '0;
    pix_if.valid   = 1'b0;
    pix_if.command = CMD_INIT_PIXEL;
    pix_if.row     = '0;
    pix_if.col     = '0;
    pix_if.pixel   = '0;
    res_if.ready   = 1'b0;
    steady         = 1'b0;
    fault_cnt      = 0;
    last_slot      = 0;
    var_floor      = VarMinReset;
    var_ceil       = VarMaxReset;
    amp_gain       = AmpReset;
    for (int i = 0; i < PoolSize; i++) begin
      pool_row[i]   = RowW'($urandom_range(FrameH - 1));
      pool_col[i]   = ColW'($urandom_range(FrameW - 1));
      pool_scene[i] = PixW'($urandom);
    end
    pool_row[0] = '0;
    pool_col[0] = '0;
    pool_row[1] = RowW'(FrameH - 1);
    pool_col[1] = ColW'(FrameW - 1);

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    check_regs();

    // Corners of the frame, both inits, equal pixel, unused command.
    push_beat(CMD_INIT_PIXEL, 9'd0,   10'd0,    8'd0);
    push_beat(CMD_INIT_BLANK, 9'd511, 10'd1023, 8'h5a);
    push_beat(CMD_INIT_PIXEL, 9'd511, 10'd0,    8'd255);
    push_beat(CMD_INIT_PIXEL, 9'd0,   10'd1023, 8'd128);
    push_beat(CMD_UPDATE,     9'd0,   10'd0,    8'd255);
    push_beat(CMD_UPDATE,     9'd0,   10'd0,    8'd255);
    push_beat(CMD_UPDATE,     9'd511, 10'd1023, 8'd254);
    push_beat(CMD_UPDATE,     9'd511, 10'd1023, 8'd0);
    push_beat(CMD_UPDATE,     9'd511, 10'd0,    8'd255);
    push_beat(CMD_UNUSED,     9'd0,   10'd0,    8'd0);
    push_beat(CMD_UNUSED,     9'd511, 10'd1023, 8'd255);
    push_beat(CMD_UPDATE,     9'd0,   10'd1023, 8'd0);
    push_beat(CMD_UPDATE,     9'd0,   10'd1023, 8'd255);
    push_beat(CMD_UPDATE,     9'd0,   10'd0,    8'd0);
    push_beat(CMD_INIT_BLANK, 9'd0,   10'd0,    8'd255);
    push_beat(CMD_UPDATE,     9'd0,   10'd0,    8'd255);
    push_beat(CMD_INIT_PIXEL, 9'h155, 10'h2aa,  8'h55);
    push_beat(CMD_INIT_PIXEL, 9'h0aa, 10'h155,  8'haa);
    push_beat(CMD_UPDATE,     9'h155, 10'h2aa,  8'haa);
    push_beat(CMD_UPDATE,     9'h0aa, 10'h155,  8'h55);
    push_beat(CMD_UPDATE,     9'h0aa, 10'h155,  8'h55);
    drain();
    run_phase(250);

    // Variance pinned at the top, so the increment has to saturate.
    set_config(8'd255, 8'd255, 8'd255);
    run_phase(60);
    set_config(8'd0, 8'd255, 8'd255);
    run_phase(150);

    // Floor above ceiling: every clamp lands on the floor.
    set_config(8'd200, 8'd10, 8'd1);
    run_phase(100);

    // Zero gain drives the variance down to the floor; no idling on either side here.
    set_config(8'd3, 8'd40, 8'd0);
    steady = 1'b1;
    run_phase(150);
    steady = 1'b0;

    set_config(PixW'($urandom), PixW'($urandom), PixW'($urandom_range(1, 255)));
    run_phase(140);

    repeat (8) @(posedge clk_i);
    if (fault_cnt == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

FILE: sigma_delta_background_subtract.f
rtl/core/sdbs_pkg.sv
rtl/core/sdbs_pix_if.sv
rtl/core/sdbs_res_if.sv
rtl/core/sigma_delta_background_subtract.sv
rtl/core/sdbs_checker.sv
dv/sigma_delta_background_subtract_tb.sv
